// ===== hw/rtl/sirs_pkg.sv =====
// ----------------------------------------------------------------------------
// sirs_pkg
// Shared types, constants and the control program of the radix text converter.
// ----------------------------------------------------------------------------
package sirs_pkg;

  localparam int MAX_RADIX  = 32;
  localparam int MIN_RADIX  = 2;
  localparam int DIGIT_W    = 6;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 8;
  localparam int ALPHA_REGS = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PC_W       = 3;

  localparam logic [CHAR_W-1:0] MINUS_SIGN = 8'h2D;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX  = 3'd0,
    REG_ALPHA0 = 3'd1,
    REG_ALPHA1 = 3'd2,
    REG_ALPHA2 = 3'd3,
    REG_ALPHA3 = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DSTEP,
    OP_STORE,
    OP_SIGN,
    OP_READ,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_BITS,
    C_MAG,
    C_DIGITS
  } cond_t;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  localparam pc_t STEP_WAIT  = 3'd0;
  localparam pc_t STEP_DSTEP = 3'd1;
  localparam pc_t STEP_STORE = 3'd2;
  localparam pc_t STEP_SIGN  = 3'd3;
  localparam pc_t STEP_READ  = 3'd4;
  localparam pc_t STEP_EMIT  = 3'd5;
  localparam pc_t STEP_END   = 3'd6;

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: STEP_WAIT};
    case (pc)
      STEP_WAIT:  w = '{op: OP_LOAD,  cond: C_NO_START, target: STEP_WAIT};
      STEP_DSTEP: w = '{op: OP_DSTEP, cond: C_BITS,     target: STEP_DSTEP};
      STEP_STORE: w = '{op: OP_STORE, cond: C_MAG,      target: STEP_DSTEP};
      STEP_SIGN:  w = '{op: OP_SIGN,  cond: C_NEVER,    target: STEP_WAIT};
      STEP_READ:  w = '{op: OP_READ,  cond: C_NEVER,    target: STEP_WAIT};
      STEP_EMIT:  w = '{op: OP_EMIT,  cond: C_DIGITS,   target: STEP_READ};
      STEP_END:   w = '{op: OP_NOP,   cond: C_ALWAYS,   target: STEP_WAIT};
      default:    w = '{op: OP_NOP,   cond: C_ALWAYS,   target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/signed_int_to_radix_string.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_radix_string
// Signed integer to text in a configured radix, most significant symbol first.
// Each digit comes from a restoring shift-subtract division, one quotient bit
// per cycle, and is then stored; then a sign step and a read and an emit step
// per character follow. Busy is high while an item runs; one item at a time.
// Characters come out on strobe for one cycle each; the receiver cannot stall.
// Synchronous reset: radix 10, alphabet zero, sequencer idle.
// ----------------------------------------------------------------------------
module signed_int_to_radix_string #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sirs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sirs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [VALUE_WIDTH-1:0]       value,
  output logic                                strobe,
  output logic [sirs_pkg::CHAR_W-1:0]         character,
  output logic                                last_char
);

  localparam int AW = $clog2(VALUE_WIDTH);
  localparam int CW = $clog2(VALUE_WIDTH + 1);

  // configuration
  logic [sirs_pkg::RADIX_W-1:0]                              radix;
  logic [sirs_pkg::ALPHA_REGS-1:0][7:0][sirs_pkg::CHAR_W-1:0] alphabet;

  // sequencer
  sirs_pkg::pc_t    pc;
  sirs_pkg::pc_t    pc_next;
  sirs_pkg::uword_t uw;
  logic             take;
  logic             strobe_next;

  // datapath
  logic [VALUE_WIDTH-1:0]      mag;
  logic [VALUE_WIDTH-1:0]      mag_load;
  logic [VALUE_WIDTH-1:0]      v;
  logic [sirs_pkg::DIGIT_W-1:0] rem;
  logic [sirs_pkg::DIGIT_W-1:0] rem_next;
  logic [AW-1:0]               bitcnt;
  logic [CW-1:0]               ndig;
  logic [CW-1:0]               ndig_dec;
  logic                        neg;
  logic [sirs_pkg::RADIX_W:0]  r_wide;
  logic [sirs_pkg::RADIX_W:0]  shifted;
  logic [sirs_pkg::RADIX_W:0]  diff;
  logic                        ge;
  logic [sirs_pkg::DIGIT_W-1:0] digit;
  logic [sirs_pkg::CHAR_W-1:0]  sym;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix    <= sirs_pkg::RADIX_W'(10);
      alphabet <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sirs_pkg::REG_RADIX:  radix       <= cfg_data[sirs_pkg::RADIX_W-1:0];
        sirs_pkg::REG_ALPHA0: alphabet[0] <= cfg_data;
        sirs_pkg::REG_ALPHA1: alphabet[1] <= cfg_data;
        sirs_pkg::REG_ALPHA2: alphabet[2] <= cfg_data;
        sirs_pkg::REG_ALPHA3: alphabet[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective radix, clamped to the supported range
  always_comb begin
    if ({1'b0, radix} < (sirs_pkg::RADIX_W + 1)'(sirs_pkg::MIN_RADIX)) begin
      r_wide = (sirs_pkg::RADIX_W + 1)'(sirs_pkg::MIN_RADIX);
    end else if ({1'b0, radix} > (sirs_pkg::RADIX_W + 1)'(sirs_pkg::MAX_RADIX)) begin
      r_wide = (sirs_pkg::RADIX_W + 1)'(sirs_pkg::MAX_RADIX);
    end else begin
      r_wide = {1'b0, radix};
    end
  end

  assign v        = value;
  assign mag_load = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;

  // one restoring division step
  assign shifted  = {rem, mag[VALUE_WIDTH-1]};
  assign ge       = shifted >= r_wide;
  assign diff     = shifted - r_wide;
  assign rem_next = ge ? diff[sirs_pkg::DIGIT_W-1:0] : shifted[sirs_pkg::DIGIT_W-1:0];

  assign ndig_dec = ndig - 1'b1;

  sirs_ram #(
    .WIDTH(sirs_pkg::DIGIT_W),
    .DEPTH(VALUE_WIDTH)
  ) u_digits (
    .clk  (clk),
    .we   (uw.op == sirs_pkg::OP_STORE),
    .waddr(ndig[AW-1:0]),
    .wdata(rem),
    .raddr(ndig_dec[AW-1:0]),
    .rdata(digit)
  );

  // digits beyond the alphabet map to zero
  assign sym = digit[sirs_pkg::DIGIT_W-1] ? '0 : alphabet[digit[4:3]][digit[2:0]];

  assign uw   = sirs_pkg::ucode(pc);
  assign busy = pc != sirs_pkg::STEP_WAIT;

  always_comb begin
    case (uw.cond)
      sirs_pkg::C_NEVER:    take = 1'b0;
      sirs_pkg::C_ALWAYS:   take = 1'b1;
      sirs_pkg::C_NO_START: take = !start;
      sirs_pkg::C_BITS:     take = bitcnt != '0;
      sirs_pkg::C_MAG:      take = mag != '0;
      sirs_pkg::C_DIGITS:   take = ndig != '0;
      default:              take = 1'b0;
    endcase
    pc_next     = take ? uw.target : pc + 1'b1;
    strobe_next = (uw.op == sirs_pkg::OP_EMIT) || ((uw.op == sirs_pkg::OP_SIGN) && neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc     <= sirs_pkg::STEP_WAIT;
      strobe <= 1'b0;
    end else begin
      pc     <= pc_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    case (uw.op)
      sirs_pkg::OP_LOAD: begin
        if (start) begin
          mag    <= mag_load;
          neg    <= v[VALUE_WIDTH-1];
          rem    <= '0;
          bitcnt <= AW'(VALUE_WIDTH - 1);
          ndig   <= '0;
        end
      end
      sirs_pkg::OP_DSTEP: begin
        mag    <= {mag[VALUE_WIDTH-2:0], ge};
        rem    <= rem_next;
        bitcnt <= bitcnt - 1'b1;
      end
      sirs_pkg::OP_STORE: begin
        ndig   <= ndig + 1'b1;
        rem    <= '0;
        bitcnt <= AW'(VALUE_WIDTH - 1);
      end
      sirs_pkg::OP_SIGN: begin
        character <= sirs_pkg::MINUS_SIGN;
        last_char <= 1'b0;
      end
      sirs_pkg::OP_READ: begin
        ndig <= ndig_dec;
      end
      sirs_pkg::OP_EMIT: begin
        character <= sym;
        last_char <= ndig == '0;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/sirs_ram.sv =====
// ----------------------------------------------------------------------------
// sirs_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module sirs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/tb_signed_int_to_radix_string.sv =====
// ----------------------------------------------------------------------------
// tb_signed_int_to_radix_string
// Self-checking bench for the signed integer to radix text converter. Numbers
// are queued with register write phases in between (radix extremes, clamped
// radix codes, reference and random alphabets). Each accepted number is
// expanded into its expected characters, and every strobed character is
// checked against the oldest one still owed.
// ----------------------------------------------------------------------------
module tb_signed_int_to_radix_string;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W        = 32;
  localparam int RADIX_AT_RESET = 10;
  localparam int IDLE_PCT       = 13;
  localparam int QUIET          = 8;
  localparam int TAIL_CYCLES    = 40;
  localparam int RAND_PHASES    = 12;
  localparam int PHASE_ITEMS    = 30;
  localparam int CALM_PHASE     = 5;
  localparam int ALPHA_IDX_W    = $clog2(sirs_pkg::ALPHA_REGS);

  localparam logic [sirs_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [sirs_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [VALUE_W-1:0] MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] MINUS_ONE = '1;

  // byte k holds the symbol of digit k
  localparam logic [8*32-1:0] DIGIT_SET = "vutsrqponmlkjihgfedcba9876543210";

  typedef enum {JOB_NUMBER, JOB_WRITE, JOB_DRAIN} job_kind_t;

  typedef struct {
    job_kind_t                        kind;
    logic [sirs_pkg::CFG_IDX_W-1:0]   index;
    logic [sirs_pkg::CFG_DATA_W-1:0]  data;
    logic [VALUE_W-1:0]               number;
    bit                               calm;
  } job_t;

  typedef struct packed {
    logic [sirs_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } glyph_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [sirs_pkg::CFG_IDX_W-1:0]   cfg_index = sirs_pkg::REG_RADIX;
  logic [sirs_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             start = 1'b0;
  logic                             busy;
  logic [VALUE_W-1:0]               value = '0;
  logic                             strobe;
  logic [sirs_pkg::CHAR_W-1:0]      character;
  logic                             last_char;

  job_t   pending[$];
  glyph_t expected_text[$];

  logic [sirs_pkg::RADIX_W-1:0]    radix_q = sirs_pkg::RADIX_W'(RADIX_AT_RESET);
  logic [sirs_pkg::CFG_DATA_W-1:0] alpha_q [sirs_pkg::ALPHA_REGS] = '{default: '0};

  int idle_run = 0;
  int n_numbers = 0;
  int n_chars = 0;
  int n_writes = 0;
  int n_errors = 0;

  signed_int_to_radix_string #(
    .VALUE_WIDTH(VALUE_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .value(value),
    .strobe(strobe),
    .character(character),
    .last_char(last_char)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    n_errors++;
  endtask

  function automatic void apply_write(input logic [sirs_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [sirs_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      sirs_pkg::REG_RADIX: radix_q = data[sirs_pkg::RADIX_W-1:0];
      sirs_pkg::REG_ALPHA0, sirs_pkg::REG_ALPHA1, sirs_pkg::REG_ALPHA2,
      sirs_pkg::REG_ALPHA3: alpha_q[ALPHA_IDX_W'(idx - sirs_pkg::REG_ALPHA0)] = data;
      default: ;
    endcase
  endfunction

  function automatic void predict_text(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [sirs_pkg::RADIX_W-1:0] r;
    logic [sirs_pkg::DIGIT_W-1:0] digs [VALUE_W+1];
    int nd;
    r = radix_q;
    if (r < sirs_pkg::MIN_RADIX) r = sirs_pkg::RADIX_W'(sirs_pkg::MIN_RADIX);
    if (r > sirs_pkg::MAX_RADIX) r = sirs_pkg::RADIX_W'(sirs_pkg::MAX_RADIX);
    mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
    nd = 0;
    do begin
      digs[nd] = sirs_pkg::DIGIT_W'(mag % r);
      mag = mag / r;
      nd++;
    end while (mag != 0);
    if (v[VALUE_W-1]) expected_text.push_back('{ch: sirs_pkg::MINUS_SIGN, last: 1'b0});
    for (int k = nd - 1; k >= 0; k--) begin
      expected_text.push_back('{ch: alpha_q[digs[k][4:3]][{digs[k][2:0], 3'b000} +: 8],
                                last: (k == 0)});
    end
  endfunction

  function automatic void add_number(input logic [VALUE_W-1:0] v, input bit calm = 1'b0);
    pending.push_back('{kind: JOB_NUMBER, index: sirs_pkg::REG_RADIX, data: '0, number: v,
                        calm: calm});
  endfunction

  function automatic void add_write(input logic [sirs_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [sirs_pkg::CFG_DATA_W-1:0] data);
    pending.push_back('{kind: JOB_WRITE, index: idx, data: data, number: '0, calm: 1'b0});
  endfunction

  function automatic void add_drain();
    pending.push_back('{kind: JOB_DRAIN, index: sirs_pkg::REG_RADIX, data: '0, number: '0,
                        calm: 1'b0});
  endfunction

  function automatic logic [sirs_pkg::CFG_DATA_W-1:0] radix_word(input int r);
    logic [sirs_pkg::CFG_DATA_W-1:0] w;
    w = {$urandom, $urandom};
    w[sirs_pkg::RADIX_W-1:0] = sirs_pkg::RADIX_W'(r);
    return w;
  endfunction

  function automatic logic [VALUE_W-1:0] random_number();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(9))
      0: begin
        v = $urandom_range(40);
        if ($urandom_range(1)) v = -v;
      end
      1: v = MOST_NEG + $urandom_range(15);
      2: v = MOST_POS - $urandom_range(15);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // driver: one word per handshake on either channel
  always @(posedge clk) begin
    job_t job;
    logic go_start;
    logic go_write;
    logic quiet;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      idle_run <= 0;
    end else begin
      if (start && !busy) begin
        predict_text(value);
        n_numbers++;
      end
      if (cfg_valid && cfg_ready) begin
        apply_write(cfg_index, cfg_data);
        n_writes++;
      end
      quiet = idle_run >= QUIET && !start && !busy && expected_text.size() == 0;
      idle_run <= (busy || start || expected_text.size() != 0) ? 0 : idle_run + 1;
      go_start = start && busy;
      go_write = cfg_valid && !cfg_ready;
      if (!go_start && !go_write && pending.size() != 0) begin
        job = pending[0];
        case (job.kind)
          JOB_NUMBER: begin
            if (job.calm || $urandom_range(99) >= IDLE_PCT) begin
              go_start = 1'b1;
              value <= job.number;
              void'(pending.pop_front());
            end
          end
          JOB_WRITE: begin
            if (quiet) begin
              go_write = 1'b1;
              cfg_index <= job.index;
              cfg_data <= job.data;
              void'(pending.pop_front());
            end
          end
          JOB_DRAIN: begin
            if (quiet) void'(pending.pop_front());
          end
          default: ;
        endcase
      end
      start <= go_start;
      cfg_valid <= go_write;
    end
  end

  // monitor
  always @(posedge clk) begin
    glyph_t want;
    if (!rst && strobe) begin
      n_chars++;
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected character %h last %b", character, last_char));
      end else begin
        want = expected_text.pop_front();
        if (character !== want.ch)
          report_mismatch($sformatf("character %h, wanted %h", character, want.ch));
        if (last_char !== want.last)
          report_mismatch($sformatf("last flag %b, wanted %b", last_char, want.last));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int r;
    // reset alphabet is all zero
    add_number('0);
    add_number(MINUS_ONE);

    for (int a = 0; a < sirs_pkg::ALPHA_REGS; a++)
      add_write(sirs_pkg::CFG_IDX_W'(sirs_pkg::REG_ALPHA0 + a), DIGIT_SET[64*a +: 64]);
    add_write(REG_SPARE_HI, {$urandom, $urandom});
    add_write(sirs_pkg::REG_RADIX, radix_word(10));
    add_number('0);
    add_number(1);
    add_number(MINUS_ONE);
    add_number(MOST_POS);
    add_number(MOST_NEG);
    add_number(10);
    add_number(-10);

    add_write(sirs_pkg::REG_RADIX, radix_word(sirs_pkg::MIN_RADIX));
    add_number(MOST_NEG);
    add_number(MOST_POS);
    add_number(MINUS_ONE);

    add_write(sirs_pkg::REG_RADIX, radix_word(sirs_pkg::MAX_RADIX));
    add_number(MOST_NEG);
    add_number(MOST_POS);
    add_number('0);
    add_number(MINUS_ONE);
    add_drain();

    // radix codes that clamp
    add_write(sirs_pkg::REG_RADIX, radix_word(0));
    add_number(5);
    add_number(-5);
    add_write(sirs_pkg::REG_RADIX, radix_word(1));
    add_number(6);
    add_write(sirs_pkg::REG_RADIX, radix_word(sirs_pkg::MAX_RADIX + 1));
    add_number(MOST_POS);
    add_write(sirs_pkg::REG_RADIX, radix_word((1 << sirs_pkg::RADIX_W) - 1));
    add_number(MOST_NEG);

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: r = sirs_pkg::MIN_RADIX;
        1: r = sirs_pkg::MAX_RADIX;
        default: r = $urandom_range((1 << sirs_pkg::RADIX_W) - 1);
      endcase
      add_write(sirs_pkg::REG_RADIX, radix_word(r));
      for (int a = 0; a < sirs_pkg::ALPHA_REGS; a++)
        add_write(sirs_pkg::CFG_IDX_W'(sirs_pkg::REG_ALPHA0 + a),
                  (p % 3 == 0) ? DIGIT_SET[64*a +: 64] : {$urandom, $urandom});
      if ($urandom_range(1))
        add_write(sirs_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
                  {$urandom, $urandom});
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        add_number(random_number(), p == CALM_PHASE);
        if (p % 4 == 2 && i == PHASE_ITEMS / 2) add_drain();
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0 || start || busy || expected_text.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_text.size() != 0)
      report_mismatch($sformatf("%0d characters never came", expected_text.size()));

    $display("converted %0d numbers into %0d characters, %0d register writes",
             n_numbers, n_chars, n_writes);
    $display("radix codes 0 to 63 incl. clamped ones, reference and random alphabets");
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
